[sv/qas_pkg.sv]
// ----------------------------------------------------------------------------
// qas_pkg
// shared types, widths and constants of the third-order upwind advection sweep
// ----------------------------------------------------------------------------
package qas_pkg;

  // field and register widths
  localparam int VAL_W     = 48;  // signed Q16.32 amounts
  localparam int K_W       = 17;  // courant, unsigned Q1.16
  localparam int CUT_W     = 47;  // cutoff, unsigned Q15.32
  localparam int CFG_W     = 47;  // widest register
  localparam int CFG_IDX_W = 1;

  // internal widths
  localparam int DIF_W  = 52;  // finite differences
  localparam int W_W    = 19;  // 1 - cr*cr, signed Q3.16
  localparam int WIDE_W = 56;  // g, scaled products, dc
  localparam int EXT_W  = 57;  // final sums before saturation
  localparam int Q_SH   = 16;  // fraction bits of courant
  localparam int Q16_ONE = 65536;

  // digit divider
  localparam int DVD_W     = 64;
  localparam int DIG_W     = 16;
  localparam int REM_W     = 10;
  localparam int DIV_STEPS = DVD_W / DIG_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int RCP_W     = 27;
  localparam logic [RCP_W-1:0] DIV6_RCP    = RCP_W'(699051);    // ceil(2^22 / 6)
  localparam int               DIV6_SH     = 22;
  localparam logic [RCP_W-1:0] DIV1000_RCP = RCP_W'(68719477);  // ceil(2^36 / 1000)
  localparam int               DIV1000_SH  = 36;

  // biases that keep the dividends non-negative
  localparam logic [DVD_W-1:0] DC_BIAS    = DVD_W'(6) << 55;
  localparam logic [DVD_W-1:0] DC_OFFSET  = DVD_W'(1) << 55;
  localparam logic [DVD_W-1:0] THR_BIAS   = DVD_W'(1000) << 47;
  localparam logic [DVD_W-1:0] THR_OFFSET = DVD_W'(1) << 47;

  // reset values of the registers
  localparam logic [K_W-1:0]   COURANT_RST = K_W'(32768);
  localparam logic [CUT_W-1:0] CUTOFF_RST  = CUT_W'(429);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COURANT = 1'b0,
    CFG_CUTOFF  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    DIV_BY_6    = 1'b0,
    DIV_BY_1000 = 1'b1
  } div_kind_e;

  typedef enum logic [1:0] {
    MUL_D2K = 2'd0,
    MUL_D3W = 2'd1,
    MUL_GK  = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic    in_load;
    logic    diff_en;
    logic    thr_load;
    logic    mul_lo;
    logic    mul_hi;
    logic    mul_add;
    mul_op_e mul_op;
    logic    g_en;
    logic    dc_load;
    logic    div_step;
    logic    emit_pend;
    logic    emit_pass;
    logic    store_pend;
    logic    sweep_clear;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic last;
  } sts_t;

  typedef struct packed {
    logic [VAL_W-1:0] aqueous;
    logic [VAL_W-1:0] bulk;
    logic             corr;
    logic             sweep_end;
  } res_t;

  // clip a wide signed sum to the 48-bit range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [EXT_W-1:0] x);
    logic signed [VAL_W-1:0] r;
    if ((&x[EXT_W-1:VAL_W-1]) || !(|x[EXT_W-1:VAL_W-1])) begin
      r = x[VAL_W-1:0];
    end else if (x[EXT_W-1]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

endpackage

[sv/qas_cdiv.sv]
// ----------------------------------------------------------------------------
// qas_cdiv
// divide a 64-bit unsigned value by 6 or 1000, one 16-bit digit per step
// ----------------------------------------------------------------------------
module qas_cdiv (
  input  logic                      clk_i,
  input  qas_pkg::div_kind_e        kind_i,
  input  logic                      load_i,
  input  logic                      step_i,
  input  logic [qas_pkg::DVD_W-1:0] dividend_i,
  output logic [qas_pkg::DVD_W-1:0] quotient_o
);
  import qas_pkg::*;

  localparam int V_W = REM_W + DIG_W;
  localparam int P_W = V_W + RCP_W;

  logic [REM_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] num_q, quo_q;
  logic [V_W-1:0]   v;
  logic [V_W-1:0]   qmul;
  logic [P_W-1:0]   prod;
  logic [DIG_W-1:0] qdig;

  // reciprocal multiply gives the exact digit since remainder < divisor
  always_comb begin
    v = {rem_q, num_q[DVD_W-1 -: DIG_W]};
    case (kind_i)
      DIV_BY_6: begin
        prod = v * DIV6_RCP;
        qdig = prod[DIV6_SH +: DIG_W];
        qmul = (V_W'(qdig) << 2) + (V_W'(qdig) << 1);
      end
      DIV_BY_1000: begin
        prod = v * DIV1000_RCP;
        qdig = prod[DIV1000_SH +: DIG_W];
        qmul = (V_W'(qdig) << 10) - (V_W'(qdig) << 4) - (V_W'(qdig) << 3);
      end
      default: begin
        prod = '0;
        qdig = '0;
        qmul = '0;
      end
    endcase
    rem_d = REM_W'(v - qmul);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      num_q <= dividend_i;
      quo_q <= '0;
    end else if (step_i) begin
      rem_q <= rem_d;
      num_q <= num_q << DIG_W;
      quo_q <= {quo_q[DVD_W-DIG_W-1:0], qdig};
    end
  end

  assign quotient_o = quo_q;

endmodule

[sv/qas_dp.sv]
// ----------------------------------------------------------------------------
// qas_dp
// datapath: neighbor registers, shared multiplier, dividers, result queue
// ----------------------------------------------------------------------------
module qas_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qas_pkg::cmd_t                    cmd_i,
  output qas_pkg::sts_t                    sts_o,
  input  logic [qas_pkg::K_W-1:0]          courant_i,
  input  logic [qas_pkg::CUT_W-1:0]        cutoff_i,
  input  logic signed [qas_pkg::VAL_W-1:0] aqueous_in_i,
  input  logic signed [qas_pkg::VAL_W-1:0] bulk_in_i,
  input  logic                             last_node_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [qas_pkg::VAL_W-1:0] aqueous_out_o,
  output logic signed [qas_pkg::VAL_W-1:0] bulk_out_o,
  output logic                             bulk_corrected_o,
  output logic                             sweep_end_o
);
  import qas_pkg::*;

  localparam int SPLIT = 28;
  localparam int PLO_W = SPLIT + 1 + W_W;
  localparam int PHI_W = WIDE_W - SPLIT + W_W;
  localparam int MS_W  = PHI_W + SPLIT + 1;

  // latched item
  logic signed [VAL_W-1:0] a_q, b_q;
  logic                    last_q;

  // sweep state
  logic signed [VAL_W-1:0] left_far_q, left_near_q, pend_aq_q, pend_bulk_q;

  // intermediates
  logic signed [DIF_W-1:0]  d1_q, d2_q, d3_q;
  logic signed [W_W-1:0]    w_q;
  logic signed [PLO_W-1:0]  plo_q;
  logic signed [PHI_W-1:0]  phi_q;
  logic signed [WIDE_W-1:0] m2_q, m3_q, g_q, gk_q;

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      a_q    <= aqueous_in_i;
      b_q    <= bulk_in_i;
      last_q <= last_node_i;
    end
  end

  // differences and 1 - cr*cr
  logic signed [DIF_W-1:0] c1_x, c0_x, cm1_x, cm2_x;
  logic signed [DIF_W-1:0] d1_d, d2_d, d3_d;
  logic [2*K_W-1:0]        kk;
  logic signed [W_W-1:0]   w_d;

  always_comb begin
    c1_x  = {{(DIF_W-VAL_W){a_q[VAL_W-1]}}, a_q};
    c0_x  = {{(DIF_W-VAL_W){pend_aq_q[VAL_W-1]}}, pend_aq_q};
    cm1_x = {{(DIF_W-VAL_W){left_near_q[VAL_W-1]}}, left_near_q};
    cm2_x = {{(DIF_W-VAL_W){left_far_q[VAL_W-1]}}, left_far_q};
    d1_d  = c1_x - cm1_x;
    d2_d  = c1_x - (c0_x <<< 1) + cm1_x;
    d3_d  = c1_x - (c0_x <<< 1) - c0_x + (cm1_x <<< 1) + cm1_x - cm2_x;
    kk    = courant_i * courant_i;
    w_d   = W_W'(Q16_ONE) - $signed({1'b0, kk[2*K_W-1:Q_SH]});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      d1_q <= d1_d;
      d2_q <= d2_d;
      d3_q <= d3_d;
      w_q  <= w_d;
    end
  end

  // shared multiplier: floor(a*c/65536), operand split in two halves
  logic signed [WIDE_W-1:0] mul_a;
  logic signed [W_W-1:0]    mul_c;
  logic signed [PLO_W-1:0]  plo_d;
  logic signed [PHI_W-1:0]  phi_d;
  logic signed [MS_W-1:0]   msum;
  logic signed [WIDE_W-1:0] mres;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_D2K: begin
        mul_a = {{(WIDE_W-DIF_W){d2_q[DIF_W-1]}}, d2_q};
        mul_c = {{(W_W-K_W){1'b0}}, courant_i};
      end
      MUL_D3W: begin
        mul_a = {{(WIDE_W-DIF_W){d3_q[DIF_W-1]}}, d3_q};
        mul_c = w_q;
      end
      MUL_GK: begin
        mul_a = g_q;
        mul_c = {{(W_W-K_W){1'b0}}, courant_i};
      end
      default: begin
        mul_a = '0;
        mul_c = '0;
      end
    endcase
    plo_d = $signed({1'b0, mul_a[SPLIT-1:0]}) * mul_c;
    phi_d = $signed(mul_a[WIDE_W-1:SPLIT]) * mul_c;
    msum  = $signed({phi_q[PHI_W-1], phi_q, {SPLIT{1'b0}}})
          + $signed({{(MS_W-PLO_W){plo_q[PLO_W-1]}}, plo_q});
    mres  = msum[Q_SH +: WIDE_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      plo_q <= plo_d;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= phi_d;
    end
    if (cmd_i.mul_add) begin
      case (cmd_i.mul_op)
        MUL_D2K: m2_q <= mres;
        MUL_D3W: m3_q <= mres;
        MUL_GK:  gk_q <= mres;
        default: ;
      endcase
    end
  end

  // g = 3*d1 - 3*m2 - m3
  logic signed [WIDE_W-1:0] d1_w, g_d;

  always_comb begin
    d1_w = {{(WIDE_W-DIF_W){d1_q[DIF_W-1]}}, d1_q};
    g_d  = (d1_w <<< 1) + d1_w - (m2_q <<< 1) - m2_q - m3_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.g_en) begin
      g_q <= g_d;
    end
  end

  // floor division by 1000 (bulk threshold) and by 6 (correction)
  logic [DVD_W-1:0] thr_dvd, dc_dvd, thr_quo, dc_quo;

  assign thr_dvd = {{(DVD_W-VAL_W){pend_bulk_q[VAL_W-1]}}, pend_bulk_q} + THR_BIAS;
  assign dc_dvd  = {{(DVD_W-WIDE_W){gk_q[WIDE_W-1]}}, gk_q} + DC_BIAS;

  qas_cdiv u_thr_div (
    .clk_i      (clk_i),
    .kind_i     (DIV_BY_1000),
    .load_i     (cmd_i.thr_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (thr_dvd),
    .quotient_o (thr_quo)
  );

  qas_cdiv u_dc_div (
    .clk_i      (clk_i),
    .kind_i     (DIV_BY_6),
    .load_i     (cmd_i.dc_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (dc_dvd),
    .quotient_o (dc_quo)
  );

  // update of the held node
  logic [DVD_W-1:0]        thr_u, dc_u;
  logic signed [EXT_W-1:0] dc_e, adc, thr_e, cut_e, thr_eff, c0_e, b_e;
  logic signed [VAL_W-1:0] aq_new, bulk_new;
  logic                    corr;

  always_comb begin
    thr_u    = thr_quo - THR_OFFSET;
    dc_u     = dc_quo - DC_OFFSET;
    dc_e     = {dc_u[WIDE_W-1], dc_u[WIDE_W-1:0]};
    thr_e    = {thr_u[WIDE_W-1], thr_u[WIDE_W-1:0]};
    adc      = dc_e[EXT_W-1] ? -dc_e : dc_e;
    cut_e    = {{(EXT_W-CUT_W){1'b0}}, cutoff_i};
    thr_eff  = (cut_e < thr_e) ? cut_e : thr_e;
    corr     = adc > thr_eff;
    c0_e     = {{(EXT_W-VAL_W){pend_aq_q[VAL_W-1]}}, pend_aq_q};
    b_e      = {{(EXT_W-VAL_W){pend_bulk_q[VAL_W-1]}}, pend_bulk_q};
    aq_new   = sat_val(c0_e - dc_e);
    bulk_new = corr ? sat_val(b_e - dc_e) : pend_bulk_q;
  end

  // neighbor and held-node registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_far_q  <= '0;
      left_near_q <= '0;
      pend_aq_q   <= '0;
      pend_bulk_q <= '0;
    end else if (cmd_i.sweep_clear) begin
      left_far_q  <= '0;
      left_near_q <= '0;
      pend_aq_q   <= '0;
      pend_bulk_q <= '0;
    end else begin
      if (cmd_i.emit_pend) begin
        left_far_q  <= left_near_q;
        left_near_q <= aq_new;
      end else if (cmd_i.emit_pass) begin
        left_far_q  <= left_near_q;
        left_near_q <= a_q;
      end
      if (cmd_i.store_pend) begin
        pend_aq_q   <= a_q;
        pend_bulk_q <= b_q;
      end
    end
  end

  // two-entry result queue
  res_t                  fifo_q [FIFO_DEPTH];
  res_t                  push_data;
  logic                  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push, pop;

  assign push = cmd_i.emit_pend | cmd_i.emit_pass;
  assign pop  = out_valid_o & ~out_stall_i;

  always_comb begin
    if (cmd_i.emit_pend) begin
      push_data = '{aqueous: aq_new, bulk: bulk_new, corr: corr, sweep_end: 1'b0};
    end else begin
      push_data = '{aqueous: a_q, bulk: b_q, corr: 1'b0, sweep_end: last_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  assign out_valid_o      = (cnt_q != '0);
  assign aqueous_out_o    = fifo_q[rd_ptr_q].aqueous;
  assign bulk_out_o       = fifo_q[rd_ptr_q].bulk;
  assign bulk_corrected_o = fifo_q[rd_ptr_q].corr;
  assign sweep_end_o      = fifo_q[rd_ptr_q].sweep_end;

  assign sts_o.out_full = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign sts_o.last     = last_q;

endmodule

[sv/qas_ctrl.sv]
// ----------------------------------------------------------------------------
// qas_ctrl
// sequencer for one node: differences, three products, division, emission
// ----------------------------------------------------------------------------
module qas_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output qas_pkg::cmd_t cmd_o,
  input  qas_pkg::sts_t sts_i
);
  import qas_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_DIFF      = 10'b00_0000_0010,
    ST_MUL_LO    = 10'b00_0000_0100,
    ST_MUL_HI    = 10'b00_0000_1000,
    ST_MUL_ADD   = 10'b00_0001_0000,
    ST_GSUM      = 10'b00_0010_0000,
    ST_DLOAD     = 10'b00_0100_0000,
    ST_DIV       = 10'b00_1000_0000,
    ST_EMIT_PEND = 10'b01_0000_0000,
    ST_EMIT_CUR  = 10'b10_0000_0000
  } state_e;

  localparam logic [1:0] POS_SAT = 2'd2;

  state_e           state_q, state_d;
  mul_op_e          mul_op_q, mul_op_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       pos_q, pos_d;
  logic             pend_valid_q, pend_valid_d;
  logic             pass;

  assign in_stall_o = (state_q != ST_IDLE);
  assign pass       = (pos_q != POS_SAT) || sts_i.last;

  always_comb begin
    state_d      = state_q;
    mul_op_d     = mul_op_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    pend_valid_d = pend_valid_q;
    cmd_o        = '0;
    cmd_o.mul_op = mul_op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = pend_valid_q ? ST_DIFF : ST_EMIT_CUR;
        end
      end
      ST_DIFF: begin
        cmd_o.diff_en  = 1'b1;
        cmd_o.thr_load = 1'b1;
        mul_op_d       = MUL_D2K;
        state_d        = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        cmd_o.mul_add = 1'b1;
        case (mul_op_q)
          MUL_D2K: begin
            mul_op_d = MUL_D3W;
            state_d  = ST_MUL_LO;
          end
          MUL_D3W: state_d = ST_GSUM;
          default: state_d = ST_DLOAD;
        endcase
      end
      ST_GSUM: begin
        cmd_o.g_en = 1'b1;
        mul_op_d   = MUL_GK;
        state_d    = ST_MUL_LO;
      end
      ST_DLOAD: begin
        cmd_o.dc_load = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_EMIT_PEND;
        end
      end
      ST_EMIT_PEND: begin
        if (!sts_i.out_full) begin
          cmd_o.emit_pend = 1'b1;
          pend_valid_d    = 1'b0;
          state_d         = ST_EMIT_CUR;
        end
      end
      ST_EMIT_CUR: begin
        if (!pass || !sts_i.out_full) begin
          if (pass) begin
            cmd_o.emit_pass = 1'b1;
          end else begin
            cmd_o.store_pend = 1'b1;
            pend_valid_d     = 1'b1;
          end
          if (sts_i.last) begin
            cmd_o.sweep_clear = 1'b1;
            pos_d             = '0;
            pend_valid_d      = 1'b0;
          end else if (pos_q != POS_SAT) begin
            pos_d = pos_q + 2'd1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mul_op_q     <= MUL_D2K;
      cnt_q        <= '0;
      pos_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      mul_op_q     <= mul_op_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      pend_valid_q <= pend_valid_d;
    end
  end

endmodule

[sv/quickest_advection_sweep.sv]
// ----------------------------------------------------------------------------
// quickest_advection_sweep
// one third-order upwind advection sweep over a line of nodes, Q16.32 amounts
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o  aqueous_in_i, bulk_in_i, last_node_i
//   out      source     out_valid_o/out_stall_i aqueous_out_o, bulk_out_o,
//                                             bulk_corrected_o, sweep_end_o
//   cfg      sink       cfg_we_i              cfg_index_i, cfg_data_i
//
// an item that releases a held inner node runs the full sequence: one shared
// 28x19 multiplier forms three scaled products in lo, hi and add steps, then
// the divisions by six and by 1000 run four 16-bit digits; other items skip both
// reset clears the sweep position, held node, neighbors and result queue;
// courant comes up at 0.5 and cutoff at 429
// a two-entry result queue parts the sides: a new item is taken while
// results wait, and the sequencer waits only when the queue is full
// ----------------------------------------------------------------------------
module quickest_advection_sweep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [qas_pkg::VAL_W-1:0]     aqueous_in_i,
  input  logic signed [qas_pkg::VAL_W-1:0]     bulk_in_i,
  input  logic                                 last_node_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [qas_pkg::VAL_W-1:0]     aqueous_out_o,
  output logic signed [qas_pkg::VAL_W-1:0]     bulk_out_o,
  output logic                                 bulk_corrected_o,
  output logic                                 sweep_end_o,
  // register writes
  input  logic                                 cfg_we_i,
  input  logic [qas_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [qas_pkg::CFG_W-1:0]            cfg_data_i
);
  import qas_pkg::*;

  // configuration registers
  logic [K_W-1:0]   courant_q;
  logic [CUT_W-1:0] cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      courant_q <= COURANT_RST;
      cutoff_q  <= CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COURANT: courant_q <= cfg_data_i[K_W-1:0];
        CFG_CUTOFF:  cutoff_q  <= cfg_data_i[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // controller to datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: holds sweep position and the held-node flag
  qas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // arithmetic, neighbor state and result queue
  qas_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .courant_i        (courant_q),
    .cutoff_i         (cutoff_q),
    .aqueous_in_i     (aqueous_in_i),
    .bulk_in_i        (bulk_in_i),
    .last_node_i      (last_node_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .aqueous_out_o    (aqueous_out_o),
    .bulk_out_o       (bulk_out_o),
    .bulk_corrected_o (bulk_corrected_o),
    .sweep_end_o      (sweep_end_o)
  );

endmodule
